// ===== rtl/core/assert_macros.svh =====
// assertion macros of the core rtl, used by hvn_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define HVN_CHECK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HVN_CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/hvn_pkg.sv =====
// types and constants of the heightmap vertex normal generator
`timescale 1ns / 1ps
package hvn_pkg;

  localparam int HEIGHT_W   = 8;
  localparam int COL_W      = 10;
  localparam int POS_W      = 11;
  localparam int Q15_W      = 16;
  localparam int UV_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int DIV_STEPS  = 17;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_COUNT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] CFG_RESET_COUNT = 11'd2;
  localparam logic [Q15_W-1:0]      Q15_ONE         = 16'h7FFF;
  localparam logic [Q15_W-1:0]      SEARCH_HI       = 16'h8000;
  localparam logic [UV_W-1:0]       UV_MAX          = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQUARE,
    ST_DEN,
    ST_NINIT,
    ST_NTSQ,
    ST_NCMP,
    ST_DINIT,
    ST_DSTEP,
    ST_EMIT1,
    ST_EMIT2
  } state_t;

  typedef enum logic [1:0] {
    COMP_X,
    COMP_Y,
    COMP_Z
  } comp_t;

  typedef enum logic {
    DIV_U,
    DIV_V
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     diff;
    logic     square;
    logic     den;
    logic     n_init;
    logic     n_tsq;
    logic     n_cmp;
    logic     n_store;
    comp_t    comp;
    logic     d_init;
    logic     d_step;
    logic     d_last;
    div_sel_t d_sel;
    logic     second;
  } hvn_cmd_t;

  typedef struct packed {
    logic row0;
    logic edge_v;
    logic two;
    logic search_done;
  } hvn_sts_t;

endpackage

// ===== rtl/core/hvn_if.sv =====
// stream and configuration channel interfaces
`timescale 1ns / 1ps
interface hvn_in_if;
  logic                          valid;
  logic                          ready;
  logic [hvn_pkg::HEIGHT_W-1:0]  height;
  modport source (output valid, height, input ready);
  modport sink (input valid, height, output ready);
endinterface

interface hvn_out_if;
  logic                               valid;
  logic                               ready;
  logic [hvn_pkg::COL_W-1:0]          vertex_col;
  logic [hvn_pkg::COL_W-1:0]          vertex_row;
  logic signed [hvn_pkg::POS_W-1:0]   pos_x_half;
  logic [hvn_pkg::HEIGHT_W-1:0]       pos_y;
  logic signed [hvn_pkg::POS_W-1:0]   pos_z_half;
  logic signed [hvn_pkg::Q15_W-1:0]   normal_x;
  logic signed [hvn_pkg::Q15_W-1:0]   normal_y;
  logic signed [hvn_pkg::Q15_W-1:0]   normal_z;
  logic [hvn_pkg::UV_W-1:0]           tex_u;
  logic [hvn_pkg::UV_W-1:0]           tex_v;
  logic                               last_in_run;
  logic                               mesh_done;
  modport source (output valid, vertex_col, vertex_row, pos_x_half, pos_y, pos_z_half,
                  normal_x, normal_y, normal_z, tex_u, tex_v, last_in_run, mesh_done,
                  input ready);
  modport sink (input valid, vertex_col, vertex_row, pos_x_half, pos_y, pos_z_half,
                normal_x, normal_y, normal_z, tex_u, tex_v, last_in_run, mesh_done,
                output ready);
endinterface

interface hvn_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hvn_pkg::CFG_IDX_W-1:0]  index;
  logic [hvn_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/hvn_ctrl.sv =====
// sequencing state machine of the vertex generator
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hvn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  hvn_pkg::hvn_sts_t sts,
  output hvn_pkg::hvn_cmd_t cmd
);
  import hvn_pkg::*;

  state_t     state, state_next;
  comp_t      comp, comp_next;
  div_sel_t   dsel, dsel_next;
  logic [4:0] cnt, cnt_next;

  // state and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      comp  <= COMP_X;
      dsel  <= DIV_U;
      cnt   <= '0;
    end else begin
      state <= state_next;
      comp  <= comp_next;
      dsel  <= dsel_next;
      cnt   <= cnt_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    comp_next  = comp;
    dsel_next  = dsel;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    cmd.comp   = comp;
    cmd.d_sel  = dsel;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (!sts.row0) state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        dsel_next = DIV_U;
        if (sts.edge_v) state_next = ST_DINIT;
        else state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_DEN;
      end
      ST_DEN: begin
        cmd.den    = 1'b1;
        comp_next  = COMP_X;
        state_next = ST_NINIT;
      end
      ST_NINIT: begin
        cmd.n_init = 1'b1;
        state_next = ST_NTSQ;
      end
      ST_NTSQ: begin
        if (sts.search_done) begin
          cmd.n_store = 1'b1;
          case (comp)
            COMP_X: begin
              comp_next  = COMP_Y;
              state_next = ST_NINIT;
            end
            COMP_Y: begin
              comp_next  = COMP_Z;
              state_next = ST_NINIT;
            end
            default: begin
              dsel_next  = DIV_U;
              state_next = ST_DINIT;
            end
          endcase
        end else begin
          cmd.n_tsq  = 1'b1;
          state_next = ST_NCMP;
        end
      end
      ST_NCMP: begin
        cmd.n_cmp  = 1'b1;
        state_next = ST_NTSQ;
      end
      ST_DINIT: begin
        cmd.d_init = 1'b1;
        cnt_next   = 5'(DIV_STEPS - 1);
        state_next = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd.d_step = 1'b1;
        if (cnt == '0) begin
          cmd.d_last = 1'b1;
          if (dsel == DIV_U) begin
            dsel_next  = DIV_V;
            state_next = ST_DINIT;
          end else begin
            state_next = ST_EMIT1;
          end
        end else begin
          cnt_next = cnt - 5'd1;
        end
      end
      ST_EMIT1: begin
        out_valid = 1'b1;
        if (out_ready) state_next = sts.two ? ST_EMIT2 : ST_IDLE;
      end
      ST_EMIT2: begin
        out_valid  = 1'b1;
        cmd.second = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // checks
  `HVN_CHECK(a_one_side, clk, rst, !(in_ready && out_valid), "input taken while result pending")
  `HVN_CHECK_NEXT(a_second_beat, clk, rst, state == ST_EMIT1 && out_ready && sts.two, state == ST_EMIT2, "last-row vertex lost")
  `HVN_CHECK_NEXT(a_row0_idle, clk, rst, cmd.capture && sts.row0, state == ST_IDLE, "first-row sample started work")

endmodule

// ===== rtl/core/hvn_dp.sv =====
// datapath: line buffer, counters, normal search unit, uv divider, result regs
`timescale 1ns / 1ps
module hvn_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_LENGTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [hvn_pkg::HEIGHT_W-1:0]       in_height,
  input  logic                               cfg_we,
  input  logic [hvn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hvn_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  hvn_pkg::hvn_cmd_t                  cmd,
  output hvn_pkg::hvn_sts_t                  sts,
  output logic [hvn_pkg::COL_W-1:0]          vertex_col,
  output logic [hvn_pkg::COL_W-1:0]          vertex_row,
  output logic signed [hvn_pkg::POS_W-1:0]   pos_x_half,
  output logic [hvn_pkg::HEIGHT_W-1:0]       pos_y,
  output logic signed [hvn_pkg::POS_W-1:0]   pos_z_half,
  output logic signed [hvn_pkg::Q15_W-1:0]   normal_x,
  output logic signed [hvn_pkg::Q15_W-1:0]   normal_y,
  output logic signed [hvn_pkg::Q15_W-1:0]   normal_z,
  output logic [hvn_pkg::UV_W-1:0]           tex_u,
  output logic [hvn_pkg::UV_W-1:0]           tex_v,
  output logic                               last_in_run,
  output logic                               mesh_done
);
  import hvn_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int LCW = $clog2(MAX_LENGTH + 1);
  localparam int KW  = (WCW > LCW) ? WCW : LCW;
  localparam int DW  = KW + 18;

  logic [CFG_DATA_W-1:0] width_count, length_count;
  logic [WCW-1:0]        col_cnt, w_cl, cur_x, x_r, w_r;
  logic [LCW-1:0]        row_cnt, l_cl, cur_z, z_r, l_r;
  logic                  wrap, edge_c, two_c, edge_r, two_r;
  logic [AW-1:0]         wr_idx, nx_idx;
  logic [HEIGHT_W-1:0]   row_mem [MAX_WIDTH];
  logic [HEIGHT_W-1:0]   rd0, rd1, h_r;

  logic [HEIGHT_W-1:0]   a_mag, b_mag;
  logic                  a_neg, b_neg;
  logic [16:0]           sqa, sqb;
  logic [31:0]           den;
  logic [15:0]           lo, hi, mid, mid_r, vsq, m_res;
  logic [HEIGHT_W-1:0]   vmag;
  logic                  vneg;
  logic [15:0]           t_val;
  logic [31:0]           tsq;
  logic [63:0]           prod;
  logic [Q15_W-1:0]      nx, ny, nz, n_val;

  logic [KW-1:0]         kk, dd;
  logic [DW-1:0]         rem, dsh, rem_n;
  logic [16:0]           q, q_n;
  logic                  ge;
  logic [UV_W-1:0]       u_r, v_r, q_sat;

  // clamp the size registers
  always_comb begin
    if (width_count < CFG_DATA_W'(2)) w_cl = WCW'(2);
    else if (32'(width_count) > MAX_WIDTH) w_cl = WCW'(MAX_WIDTH);
    else w_cl = WCW'(width_count);
    if (length_count < CFG_DATA_W'(2)) l_cl = LCW'(2);
    else if (32'(length_count) > MAX_LENGTH) l_cl = LCW'(MAX_LENGTH);
    else l_cl = LCW'(length_count);
  end

  // current position and its flags
  assign wrap   = (col_cnt >= w_cl) || (row_cnt >= l_cl);
  assign cur_x  = wrap ? '0 : col_cnt;
  assign cur_z  = wrap ? '0 : row_cnt;
  assign edge_c = ({1'b0, cur_x} + 1'b1) >= {1'b0, w_cl};
  assign two_c  = ({1'b0, cur_z} + 1'b1) >= {1'b0, l_cl};
  assign wr_idx = cur_x[AW-1:0];
  assign nx_idx = cur_x[AW-1:0] + 1'b1;

  // config registers and raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      width_count  <= CFG_RESET_COUNT;
      length_count <= CFG_RESET_COUNT;
      col_cnt      <= '0;
      row_cnt      <= '0;
    end else begin
      if (cmd.capture) begin
        if (edge_c) begin
          col_cnt <= '0;
          row_cnt <= two_c ? '0 : cur_z + 1'b1;
        end else begin
          col_cnt <= cur_x + 1'b1;
          row_cnt <= cur_z;
        end
      end
      if (cfg_we && (cfg_index == REG_WIDTH_COUNT || cfg_index == REG_LENGTH_COUNT)) begin
        if (cfg_index == REG_WIDTH_COUNT) width_count <= cfg_data;
        else length_count <= cfg_data;
        col_cnt <= '0;
        row_cnt <= '0;
      end
    end
  end

  // line buffer: old row read at x and x+1, new sample written at x
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_mem[wr_idx] <= in_height;
      rd0             <= row_mem[wr_idx];
      rd1             <= row_mem[nx_idx];
    end
  end

  // capture of the beat's position
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r    <= cur_x;
      z_r    <= cur_z;
      w_r    <= w_cl;
      l_r    <= l_cl;
      h_r    <= in_height;
      edge_r <= edge_c;
      two_r  <= two_c;
    end
  end

  // height differences and squared terms
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      a_neg <= !edge_r && (rd1 < rd0);
      a_mag <= edge_r ? '0 : ((rd1 < rd0) ? rd0 - rd1 : rd1 - rd0);
      b_neg <= h_r < rd0;
      b_mag <= (h_r < rd0) ? rd0 - h_r : h_r - rd0;
    end
    if (cmd.square) begin
      sqa <= 17'(a_mag) * 17'(a_mag) + 17'd1;
      sqb <= 17'(b_mag) * 17'(b_mag) + 17'd1;
    end
    if (cmd.den) den <= 32'(34'(sqa) * 34'(sqb));
  end

  // component select for the search
  always_comb begin
    case (cmd.comp)
      COMP_X: begin
        vmag = a_mag;
        vneg = a_neg;
      end
      COMP_Y: begin
        vmag = HEIGHT_W'(1);
        vneg = 1'b1;
      end
      default: begin
        vmag = b_mag;
        vneg = b_neg;
      end
    endcase
  end

  // trial value of the search
  assign mid   = 16'((17'(lo) + 17'(hi) + 17'd1) >> 1);
  assign t_val = 16'(({1'b0, mid} << 1) - 17'd1);
  assign prod  = 64'(tsq) * 64'(den);
  assign m_res = lo;
  assign n_val = vneg ? Q15_W'(16'd0 - m_res) : ((m_res > 16'd32767) ? Q15_ONE : m_res);

  // binary search of round(32768*v/sqrt(den)): largest m with (2m-1)^2*den <= v^2*2^32
  always_ff @(posedge clk) begin
    if (cmd.n_init) begin
      lo  <= '0;
      hi  <= SEARCH_HI;
      vsq <= 16'(vmag) * 16'(vmag);
    end
    if (cmd.n_tsq) begin
      tsq   <= 32'(t_val) * 32'(t_val);
      mid_r <= mid;
    end
    if (cmd.n_cmp) begin
      if (prod <= {16'd0, vsq, 32'd0}) lo <= mid_r;
      else hi <= mid_r - 16'd1;
    end
  end

  // normal registers, edge value preset at capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      nx <= '0;
      ny <= Q15_ONE;
      nz <= '0;
    end else if (cmd.n_store) begin
      case (cmd.comp)
        COMP_X:  nx <= n_val;
        COMP_Y:  ny <= n_val;
        default: nz <= n_val;
      endcase
    end
  end

  // uv divider operands
  always_comb begin
    if (cmd.d_sel == DIV_U) begin
      kk = KW'(x_r);
      dd = KW'(w_r) - 1'b1;
    end else begin
      kk = KW'(z_r) - 1'b1;
      dd = KW'(l_r) - 1'b1;
    end
  end

  assign ge    = rem >= dsh;
  assign rem_n = ge ? rem - dsh : rem;
  assign q_n   = {q[15:0], ge};
  assign q_sat = q_n[16] ? UV_MAX : q_n[15:0];

  // restoring divider: (k*2^17 + d) / (2d), one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.d_init) begin
      rem <= (DW'(kk) << 17) + DW'(dd);
      dsh <= DW'(dd) << 17;
      q   <= '0;
    end else if (cmd.d_step) begin
      rem <= rem_n;
      dsh <= dsh >> 1;
      q   <= q_n;
      if (cmd.d_last) begin
        if (cmd.d_sel == DIV_U) u_r <= q_sat;
        else v_r <= q_sat;
      end
    end
  end

  // status to the controller
  always_comb begin
    sts.row0        = (cur_z == '0);
    sts.edge_v      = edge_r;
    sts.two         = two_r;
    sts.search_done = (lo == hi);
  end

  // result beat: vertex above, or the last-row vertex
  always_comb begin
    vertex_col = COL_W'(int'(x_r));
    pos_x_half = POS_W'(2 * int'(x_r) - int'(w_r) + 1);
    tex_u      = u_r;
    if (cmd.second) begin
      vertex_row  = COL_W'(int'(z_r));
      pos_y       = h_r;
      pos_z_half  = POS_W'(2 * int'(z_r) - int'(l_r) + 1);
      normal_x    = '0;
      normal_y    = Q15_ONE;
      normal_z    = '0;
      tex_v       = UV_MAX;
      last_in_run = 1'b1;
      mesh_done   = edge_r;
    end else begin
      vertex_row  = COL_W'(int'(z_r) - 1);
      pos_y       = rd0;
      pos_z_half  = POS_W'(2 * int'(z_r) - 2 - int'(l_r) + 1);
      normal_x    = nx;
      normal_y    = ny;
      normal_z    = nz;
      tex_v       = v_r;
      last_in_run = !two_r;
      mesh_done   = 1'b0;
    end
  end

endmodule

// ===== rtl/core/heightmap_vertex_normal_gen_core.sv =====
// top level of the heightmap vertex normal generator
//
//   channel   dir   handshake      payload
//   sample    in    valid/ready    height
//   vertex    out   valid/ready    vertex fields, last_in_run, mesh_done
//   cfg       in    valid/ready    index, data (0 width_count, 1 length_count)
//
// one sample at a time; a first-row sample is only captured and gives no vertex
// an edge vertex skips the normal search; an inner one runs the shared normal search
// (up to 16 trials per component, each a squaring and a compare state); both then
// run the 17-step uv divider for u and v; a last-row sample adds a second vertex beat
// sync reset sets both counts to 2 and the counters to zero; line buffer is not cleared
// a stalled vertex beat holds its payload; cfg is always ready, and a width or length write restarts the mesh
`timescale 1ns / 1ps
module heightmap_vertex_normal_gen_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_LENGTH = 1024
) (
  input logic        clk,
  input logic        rst,
  hvn_in_if.sink     sample,
  hvn_out_if.source  vertex,
  hvn_cfg_if.sink    cfg
);
  import hvn_pkg::*;

  hvn_cmd_t cmd;
  hvn_sts_t sts;
  logic     cfg_we;

  // config beats are always taken
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  hvn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (vertex.valid),
    .out_ready (vertex.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hvn_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_height   (sample.height),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .cmd         (cmd),
    .sts         (sts),
    .vertex_col  (vertex.vertex_col),
    .vertex_row  (vertex.vertex_row),
    .pos_x_half  (vertex.pos_x_half),
    .pos_y       (vertex.pos_y),
    .pos_z_half  (vertex.pos_z_half),
    .normal_x    (vertex.normal_x),
    .normal_y    (vertex.normal_y),
    .normal_z    (vertex.normal_z),
    .tex_u       (vertex.tex_u),
    .tex_v       (vertex.tex_v),
    .last_in_run (vertex.last_in_run),
    .mesh_done   (vertex.mesh_done)
  );

endmodule
